>>> sv/kwm_pkg.sv
// Shared transaction types and operation/status codes of the k-way sorted merge.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  // Number of lists and value width; both are fixed by the transaction fields.
  localparam int unsigned NUM_LISTS  = 8;
  localparam int unsigned VALUE_BITS = 32;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PULL  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Status codes returned with every result.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         list_index;
    logic signed [31:0] value;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] merged_value;
    logic [2:0]         source_list;
  } out_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } kwm_state_e;

endpackage

`default_nettype wire

>>> sv/kwm_store.sv
// List memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kwm_store #(
  parameter int unsigned ENTRIES = 512,
  parameter int unsigned WIDTH   = 32,
  localparam int unsigned AddrW  = $clog2(ENTRIES)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [ENTRIES];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/kwm_ctrl.sv
// Merge controller: per-list fill and taken counters, head scan and result forming.
`timescale 1ns / 1ps
`default_nettype none

module kwm_ctrl #(
  parameter int unsigned LIST_DEPTH = 64,
  localparam int unsigned AddrW     = $clog2(kwm_pkg::NUM_LISTS * LIST_DEPTH)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire kwm_pkg::in_t                   in_data_i,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output kwm_pkg::out_t                       res_data_o,
  output logic                                mem_we_o,
  output logic [AddrW-1:0]                    mem_waddr_o,
  output logic [kwm_pkg::VALUE_BITS-1:0]      mem_wdata_o,
  output logic                                mem_re_o,
  output logic [AddrW-1:0]                    mem_raddr_o,
  input  wire logic [kwm_pkg::VALUE_BITS-1:0] mem_rdata_i
);

  import kwm_pkg::*;

  localparam int unsigned ListW = $clog2(NUM_LISTS);
  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);
  localparam logic [VALUE_BITS-1:0] SignFlip = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  kwm_state_e            state_q, state_d;
  in_t                   item_q, item_d;
  logic [1:0]            load_status_q, load_status_d;
  logic [ListW:0]        scan_q, scan_d;
  logic [AddrW-1:0]      base_q, base_d;
  logic                  cmp_pend_q, cmp_pend_d;
  logic [ListW-1:0]      cmp_list_q, cmp_list_d;
  logic                  found_q, found_d;
  logic [VALUE_BITS-1:0] best_q, best_d;
  logic [ListW-1:0]      best_list_q, best_list_d;
  logic [CntW-1:0]       fill_q [NUM_LISTS];
  logic [CntW-1:0]       fill_d [NUM_LISTS];
  logic [CntW-1:0]       taken_q [NUM_LISTS];
  logic [CntW-1:0]       taken_d [NUM_LISTS];

  logic                  in_fire;
  logic                  res_fire;
  logic                  list_ok;
  logic                  load_ok;
  logic                  scan_busy;
  logic                  take_new;
  logic [ListW-1:0]      cnt_sel;
  logic [CntW-1:0]       fill_rd;
  logic [CntW-1:0]       taken_rd;
  logic [VALUE_BITS-1:0] head_key;
  logic [VALUE_BITS-1:0] best_key;

  assign in_fire   = in_valid_i && (state_q == S_IDLE);
  assign res_fire  = res_valid_o && res_ready_i;
  assign list_ok   = int'(in_data_i.list_index) < int'(NUM_LISTS);
  assign scan_busy = scan_q < (ListW + 1)'(NUM_LISTS);

  // The counters have one read port; idle serves the incoming load, scan the swept list.
  assign cnt_sel  = (state_q == S_IDLE) ? ListW'(in_data_i.list_index) : scan_q[ListW-1:0];
  assign fill_rd  = fill_q[cnt_sel];
  assign taken_rd = taken_q[cnt_sel];
  assign load_ok  = list_ok && (fill_rd < CntW'(LIST_DEPTH));

  // Signed order becomes unsigned order once the sign bit is flipped.
  // A strict compare keeps the lowest list on equal heads.
  assign head_key = mem_rdata_i ^ SignFlip;
  assign best_key = best_q ^ SignFlip;
  assign take_new = cmp_pend_q && (!found_q || (head_key < best_key));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_data_i.func == FUNC_PULL) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (!scan_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs toward the handshake and the result register.
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);
    res_data_o  = '0;
    if (item_q.func == FUNC_PULL) begin
      if (found_q) begin
        res_data_o.status       = STATUS_OK;
        res_data_o.merged_value = $signed(32'(best_q));
        res_data_o.source_list  = 3'(best_list_q);
      end else begin
        res_data_o.status = STATUS_EMPTY;
      end
    end else begin
      res_data_o.status = load_status_q;
    end
  end

  // Counters, memory accesses and the running minimum of the head scan.
  always_comb begin
    item_d        = item_q;
    load_status_d = load_status_q;
    scan_d        = scan_q;
    base_d        = base_q;
    cmp_pend_d    = 1'b0;
    cmp_list_d    = cmp_list_q;
    found_d       = found_q;
    best_d        = best_q;
    best_list_d   = best_list_q;
    fill_d        = fill_q;
    taken_d       = taken_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = AddrW'(in_data_i.list_index) * AddrW'(LIST_DEPTH) + AddrW'(fill_rd);
    mem_wdata_o   = VALUE_BITS'($unsigned(in_data_i.value));
    mem_re_o      = 1'b0;
    mem_raddr_o   = base_q + AddrW'(taken_rd);

    // A new transaction: loads and clears complete here, pulls start the scan.
    if (in_fire) begin
      item_d        = in_data_i;
      load_status_d = STATUS_OK;
      scan_d        = '0;
      base_d        = '0;
      found_d       = 1'b0;
      best_list_d   = '0;
      unique case (in_data_i.func)
        FUNC_LOAD: begin
          if (load_ok) begin
            mem_we_o        = 1'b1;
            fill_d[cnt_sel] = fill_rd + CntW'(1);
          end else begin
            load_status_d = STATUS_FULL;
          end
        end
        FUNC_CLEAR: begin
          fill_d  = '{default: '0};
          taken_d = '{default: '0};
        end
        default: begin
        end
      endcase
    end

    // Scan issues one head read per cycle; empty lists are skipped.
    if ((state_q == S_SCAN) && scan_busy) begin
      mem_re_o   = taken_rd < fill_rd;
      cmp_pend_d = mem_re_o;
      cmp_list_d = scan_q[ListW-1:0];
      scan_d     = scan_q + (ListW + 1)'(1);
      base_d     = base_q + AddrW'(LIST_DEPTH);
    end

    // The head read in the previous cycle is compared against the best so far.
    if (take_new) begin
      found_d     = 1'b1;
      best_d      = mem_rdata_i;
      best_list_d = cmp_list_q;
    end

    // The pulled head leaves its list once the result is handed over.
    if (res_fire && (item_q.func == FUNC_PULL) && found_q) begin
      taken_d[best_list_q] = taken_q[best_list_q] + CntW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_q     <= '0;
      base_q     <= '0;
      cmp_pend_q <= 1'b0;
      found_q    <= 1'b0;
      fill_q     <= '{default: '0};
      taken_q    <= '{default: '0};
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      base_q     <= base_d;
      cmp_pend_q <= cmp_pend_d;
      found_q    <= found_d;
      fill_q     <= fill_d;
      taken_q    <= taken_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q        <= item_d;
    load_status_q <= load_status_d;
    cmp_list_q    <= cmp_list_d;
    best_q        <= best_d;
    best_list_q   <= best_list_d;
  end

endmodule

`default_nettype wire

>>> sv/k_way_sorted_merge_top.sv
// Top level of the k-way sorted merge: controller, list memory and result register.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to NUM_LISTS sorted lists of LIST_DEPTH values each in one
// synchronous memory and returns exactly one result transaction per input
// transaction. A load appends a value to a list (status 1 if the list is full or
// the index is out of range), a pull returns and removes the smallest head with the
// lowest list winning ties (status 2 if every list is empty), and a clear empties
// all lists. A load, a clear or an unused code goes straight to the result. A
// pull first scans the lists: the controller reads one list head per cycle
// through the memory's single read port and compares it in the cycle after.
// The next input transaction is accepted while a result still waits in the output
// register. No clearing pass is needed after reset.
module k_way_sorted_merge_top #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire kwm_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output kwm_pkg::out_t     out_data_o
);

  import kwm_pkg::*;

  localparam int unsigned Entries = NUM_LISTS * LIST_DEPTH;
  localparam int unsigned AddrW   = $clog2(Entries);

  logic                  res_valid;
  logic                  res_ready;
  out_t                  res_data;
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [AddrW-1:0]      mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;

  logic                  out_valid_q, out_valid_d;
  out_t                  out_data_q, out_data_d;

  kwm_ctrl #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_data_o (res_data),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  kwm_store #(
    .ENTRIES(Entries),
    .WIDTH  (VALUE_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output register: takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An accepted transaction leaves the controller not ready in the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o
  ) else $error("controller stayed ready after accepting a transaction");

  // Handing a result to the output register returns the controller to idle.
  a_idle_after_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> (in_ready_o && out_valid_o)
  ) else $error("result handoff did not free the controller");

  // Only a successful pull carries a value or a source list.
  a_empty_fields_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != STATUS_OK)) |->
      ((out_data_o.merged_value == '0) && (out_data_o.source_list == '0))
  ) else $error("non-ok result carries a value or source list");

endmodule

`default_nettype wire
